[rtl/core/rgbe_rle_pkg.sv]
// Shared types and constants for the RGBE scanline run-length decoder.
package rgbe_rle_pkg;

  localparam int COORD_W       = 15;
  localparam int BYTE_W        = 8;
  localparam int REP_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int MAX_WIDTH     = 32767;
  localparam int MIN_RLE_WIDTH = 8;
  localparam int RUN_BASE      = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_WIDTH_MISMATCH = 2'd0;
  localparam logic [1:0] ERR_ZERO_COUNT     = 2'd1;
  localparam logic [1:0] ERR_RUN_OVERFLOW   = 2'd2;
  localparam logic [1:0] ERR_NONE           = 2'd0;

  localparam logic [1:0] COMP_RED      = 2'd0;
  localparam logic [1:0] COMP_EXPONENT = 2'd3;

  localparam logic [BYTE_W-1:0] RLE_MARK = 8'd2;

  typedef enum logic [2:0] {
    MODE_HDR,
    MODE_COUNT,
    MODE_RUNVAL,
    MODE_LIT,
    MODE_RAW,
    MODE_DONE,
    MODE_ERR
  } mode_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         error_code;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [1:0]         component;
    logic [BYTE_W-1:0]  value;
    logic [REP_W-1:0]   repeat_res;
    logic               last_of_run;
    logic               image_done;
  } result_t;

endpackage

[rtl/core/rgbe_scanline_rle_decoder_top.sv]
// RGBE scanline decoder: byte stream in, component write records and error reports out.
// A record is queued when its byte is accepted and offered once those ahead of it pop.
// One byte per cycle while in_stall is low; a byte makes at most three records, drained
// one per cycle while out_stall is low through a four-entry queue that sets in_stall.
// Reset (synchronous, active high) returns the decoder to the line-header state at row 0
// and sets both image dimensions to 1; the result queue is emptied.
module rgbe_scanline_rle_decoder_top
  import rgbe_rle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    byte_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [1:0]           error_code,
  output logic [COORD_W-1:0]   row,
  output logic [COORD_W-1:0]   column,
  output logic [1:0]           component,
  output logic [BYTE_W-1:0]    value,
  output logic [REP_W-1:0]     repeat_res,
  output logic                 last_of_run,
  output logic                 image_done
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  // configuration
  logic [COORD_W-1:0] image_width;
  logic [COORD_W-1:0] image_height;

  // decoder state
  mode_t              mode, mode_next;
  logic [1:0]         header_index, header_index_next;
  logic [BYTE_W-1:0]  held [MAX_RESULTS];
  logic [BYTE_W-1:0]  held_next [MAX_RESULTS];
  logic [1:0]         plane_index, plane_index_next;
  logic [COORD_W-1:0] column_pos, column_pos_next;
  logic [COORD_W-1:0] row_pos, row_pos_next;
  logic [BYTE_W-1:0]  pending_count, pending_count_next;
  logic [1:0]         raw_byte_index, raw_byte_index_next;

  // result queue
  result_t            queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  rd_ptr, wr_ptr;
  logic [QCNT_W-1:0]  q_count;

  result_t            res [MAX_RESULTS];
  logic [NRES_W-1:0]  n_res;

  logic accept, pop;

  assign in_stall  = q_count > QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
  assign accept    = in_valid && !in_stall;
  assign out_valid = q_count != '0;
  assign pop       = out_valid && !out_stall;

  assign kind        = queue[rd_ptr].kind;
  assign error_code  = queue[rd_ptr].error_code;
  assign row         = queue[rd_ptr].row;
  assign column      = queue[rd_ptr].column;
  assign component   = queue[rd_ptr].component;
  assign value       = queue[rd_ptr].value;
  assign repeat_res  = queue[rd_ptr].repeat_res;
  assign last_of_run = queue[rd_ptr].last_of_run;
  assign image_done  = queue[rd_ptr].image_done;

  // Shared decode terms. Sums carry one extra bit so a position can meet the width.
  logic [COORD_W:0]   width_ext, col_inc, row_inc, plane_sum;
  logic [COORD_W-1:0] rem;
  logic               col_end, row_end, plane_end, last_plane;
  logic               narrow, hdr_bad, hdr_match;
  logic               cnt_run, cnt_zero, cnt_over;
  logic [BYTE_W-1:0]  cnt_len, plane_step;

  assign width_ext  = {1'b0, image_width};
  assign col_inc    = {1'b0, column_pos} + (COORD_W + 1)'(1);
  assign row_inc    = {1'b0, row_pos} + (COORD_W + 1)'(1);
  assign plane_step = (mode == MODE_RUNVAL) ? pending_count : 8'd1;
  assign plane_sum  = {1'b0, column_pos} + {{(COORD_W + 1 - BYTE_W){1'b0}}, plane_step};
  assign col_end    = col_inc >= width_ext;
  assign row_end    = row_inc >= {1'b0, image_height};
  assign plane_end  = plane_sum >= width_ext;
  assign last_plane = plane_index == COMP_EXPONENT;
  assign rem        = (column_pos < image_width) ? image_width - column_pos : '0;

  assign narrow    = (header_index == 2'd0) &&
                     ((image_width < COORD_W'(MIN_RLE_WIDTH)) ||
                      ({1'b0, image_width} > (COORD_W + 1)'(MAX_WIDTH)));
  assign hdr_bad   = (header_index < 2'd2) ? (byte_in != RLE_MARK) : byte_in[BYTE_W-1];
  assign hdr_match = {held[2], byte_in} == {1'b0, image_width};

  // A count above the run base is a run of (count - 128); the rest is a literal count.
  assign cnt_run  = byte_in > 8'(RUN_BASE);
  assign cnt_len  = cnt_run ? {1'b0, byte_in[BYTE_W-2:0]} : byte_in;
  assign cnt_zero = byte_in == '0;
  assign cnt_over = {{(COORD_W - BYTE_W){1'b0}}, cnt_len} > rem;

  // Next state.
  always_comb begin
    mode_next           = mode;
    header_index_next   = header_index;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      held_next[i] = held[i];
    end
    plane_index_next    = plane_index;
    column_pos_next     = column_pos;
    row_pos_next        = row_pos;
    pending_count_next  = pending_count;
    raw_byte_index_next = raw_byte_index;
    unique case (mode)
      MODE_HDR: begin
        if (narrow) begin
          mode_next           = MODE_RAW;
          column_pos_next     = '0;
          raw_byte_index_next = 2'd1;
        end else if (header_index == 2'd3) begin
          header_index_next = '0;
          plane_index_next  = '0;
          column_pos_next   = '0;
          if (hdr_match) begin
            mode_next          = MODE_COUNT;
            pending_count_next = '0;
          end else begin
            mode_next = MODE_ERR;
          end
        end else if (!hdr_bad) begin
          held_next[header_index] = byte_in;
          header_index_next       = header_index + 2'd1;
        end else begin
          // The held header bytes and this byte fill components of column 0.
          mode_next           = MODE_RAW;
          column_pos_next     = '0;
          header_index_next   = '0;
          raw_byte_index_next = header_index + 2'd1;
        end
      end
      MODE_COUNT: begin
        if (cnt_zero || cnt_over) begin
          mode_next = MODE_ERR;
        end else begin
          pending_count_next = cnt_len;
          mode_next          = cnt_run ? MODE_RUNVAL : MODE_LIT;
        end
      end
      MODE_RUNVAL, MODE_LIT: begin
        if (plane_end) begin
          column_pos_next    = '0;
          pending_count_next = '0;
          if (last_plane) begin
            plane_index_next = '0;
            row_pos_next     = row_inc[COORD_W-1:0];
            if (row_end) begin
              mode_next = MODE_DONE;
            end else begin
              mode_next         = MODE_HDR;
              header_index_next = '0;
            end
          end else begin
            plane_index_next = plane_index + 2'd1;
            mode_next        = MODE_COUNT;
          end
        end else begin
          column_pos_next = plane_sum[COORD_W-1:0];
          if (mode == MODE_RUNVAL) begin
            pending_count_next = '0;
            mode_next          = MODE_COUNT;
          end else begin
            pending_count_next = (pending_count != '0) ? pending_count - 8'd1 : '0;
            mode_next          = (pending_count > 8'd1) ? MODE_LIT : MODE_COUNT;
          end
        end
      end
      MODE_RAW: begin
        if (raw_byte_index == COMP_EXPONENT) begin
          raw_byte_index_next = '0;
          if (col_end) begin
            column_pos_next = '0;
            row_pos_next    = row_inc[COORD_W-1:0];
            if (row_end) begin
              mode_next = MODE_DONE;
            end
          end else begin
            column_pos_next = col_inc[COORD_W-1:0];
          end
        end else begin
          raw_byte_index_next = raw_byte_index + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Results of the current byte.
  always_comb begin
    result_t base;
    base.kind        = KIND_WRITE;
    base.error_code  = ERR_NONE;
    base.row         = row_pos;
    base.column      = column_pos;
    base.component   = plane_index;
    base.value       = byte_in;
    base.repeat_res  = REP_W'(1);
    base.last_of_run = 1'b0;
    base.image_done  = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = base;
    end
    n_res = '0;
    unique case (mode)
      MODE_HDR: begin
        if (narrow) begin
          res[0].column    = '0;
          res[0].component = COMP_RED;
          n_res            = NRES_W'(1);
        end else if (header_index == 2'd3) begin
          if (!hdr_match) begin
            res[0].kind       = KIND_ERROR;
            res[0].error_code = ERR_WIDTH_MISMATCH;
            res[0].column     = '0;
            res[0].component  = COMP_RED;
            res[0].repeat_res = '0;
            n_res             = NRES_W'(1);
          end
        end else if (hdr_bad) begin
          for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].column    = '0;
            res[i].component = 2'(i);
            res[i].value     = (2'(i) == header_index) ? byte_in : held[i];
          end
          n_res = NRES_W'(header_index) + NRES_W'(1);
        end
      end
      MODE_COUNT: begin
        if (cnt_zero || cnt_over) begin
          res[0].kind       = KIND_ERROR;
          res[0].error_code = cnt_zero ? ERR_ZERO_COUNT : ERR_RUN_OVERFLOW;
          res[0].repeat_res = '0;
          n_res             = NRES_W'(1);
        end
      end
      MODE_RUNVAL, MODE_LIT: begin
        res[0].repeat_res = (mode == MODE_RUNVAL) ? pending_count[REP_W-1:0] : REP_W'(1);
        res[0].image_done = plane_end && last_plane && row_end;
        n_res             = NRES_W'(1);
      end
      MODE_RAW: begin
        res[0].component  = raw_byte_index;
        res[0].image_done = (raw_byte_index == COMP_EXPONENT) && col_end && row_end;
        n_res             = NRES_W'(1);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (NRES_W'(i + 1) == n_res) begin
        res[i].last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= COORD_W'(1);
      image_height <= COORD_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_HDR;
      header_index   <= '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        held[i] <= '0;
      end
      plane_index    <= '0;
      column_pos     <= '0;
      row_pos        <= '0;
      pending_count  <= '0;
      raw_byte_index <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      header_index   <= header_index_next;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        held[i] <= held_next[i];
      end
      plane_index    <= plane_index_next;
      column_pos     <= column_pos_next;
      row_pos        <= row_pos_next;
      pending_count  <= pending_count_next;
      raw_byte_index <= raw_byte_index_next;
    end
  end

  // Result queue payload: up to three entries written per accepted byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (NRES_W'(i) < n_res) begin
          queue[QPTR_W'(wr_ptr + QPTR_W'(i))] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= QPTR_W'(wr_ptr + QPTR_W'(n_res));
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
    end
  end

endmodule
